// ----- hw/rtl/pss_pkg.sv -----
// Shared types, widths and controller states for the priority schedule statistics unit.
// Used by the divider, datapath, controller and top level.
// Depends on nothing.
`timescale 1ns / 1ps

package pss_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ID_W      = 7;
  localparam int BURST_W   = 16;
  localparam int PRIO_W    = 8;
  localparam int SUM_W     = 22;
  localparam int TOT_W     = SUM_W + CNT_W;
  localparam int DCNT_W    = $clog2(TOT_W + 1);

  typedef logic [IDX_W-1:0]   pss_idx_t;
  typedef logic [CNT_W-1:0]   pss_cnt_t;
  typedef logic [ID_W-1:0]    pss_id_t;
  typedef logic [BURST_W-1:0] pss_burst_t;
  typedef logic [PRIO_W-1:0]  pss_prio_t;
  typedef logic [SUM_W-1:0]   pss_sum_t;
  typedef logic [TOT_W-1:0]   pss_tot_t;
  typedef logic [DCNT_W-1:0]  pss_dcnt_t;

  typedef struct packed {
    pss_id_t    id;
    pss_prio_t  prio;
    pss_burst_t burst;
  } pss_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_RD_J,
    ST_CMP_J,
    ST_WR_SEL,
    ST_WR_I,
    ST_DIV_W,
    ST_WAIT_W,
    ST_DIV_T,
    ST_WAIT_T,
    ST_EM_RD,
    ST_EMIT
  } pss_state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_j;
    logic ld_i;
    logic cmp_j;
    logic wr_sel;
    logic wr_i;
    logic div_start;
    logic div_sel_t;
    logic cap_w;
    logic cap_t;
    logic emit;
  } pss_cmd_t;

  typedef struct packed {
    logic last_i;
    logic last_j;
    logic div_done;
  } pss_sts_t;

endpackage

// ----- hw/rtl/pss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pss_div.sv -----
// Restoring divider, one quotient bit per cycle, for the batch averages.
// Depends on pss_pkg.
`timescale 1ns / 1ps

module pss_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  pss_pkg::pss_tot_t dividend_i,
  input  pss_pkg::pss_cnt_t divisor_i,
  output logic              done_o,
  output pss_pkg::pss_tot_t quotient_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  pss_pkg::pss_dcnt_t     cnt_q, cnt_d;
  pss_pkg::pss_cnt_t      rem_q, rem_d;
  pss_pkg::pss_tot_t      quo_q, quo_d;
  logic [pss_pkg::CNT_W:0] trial;
  logic [pss_pkg::CNT_W:0] diff;
  logic                   ge;

  always_comb begin
    trial  = {rem_q, quo_q[pss_pkg::TOT_W-1]};
    diff   = trial - {1'b0, divisor_i};
    ge     = (trial >= {1'b0, divisor_i});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = pss_pkg::pss_dcnt_t'(pss_pkg::TOT_W);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[pss_pkg::CNT_W-1:0] : trial[pss_pkg::CNT_W-1:0];
      quo_d = {quo_q[pss_pkg::TOT_W-2:0], ge};
      cnt_d = cnt_q - pss_pkg::pss_dcnt_t'(1);
      if (cnt_q == pss_pkg::pss_dcnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hw/rtl/pss_dp.sv -----
// Datapath: job store, selection sort registers, running sums, divider and result registers.
// Depends on pss_pkg, pss_ram and pss_div.
`timescale 1ns / 1ps

module pss_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pss_pkg::pss_cmd_t   cmd_i,
  output pss_pkg::pss_sts_t   sts_o,
  input  pss_pkg::pss_burst_t burst_i,
  input  pss_pkg::pss_prio_t  prio_i,
  output logic                valid_o,
  output pss_pkg::pss_id_t    job_id_o,
  output pss_pkg::pss_burst_t job_burst_o,
  output pss_pkg::pss_sum_t   wait_time_o,
  output pss_pkg::pss_sum_t   turnaround_o,
  output pss_pkg::pss_sum_t   avg_wait_o,
  output pss_pkg::pss_sum_t   avg_turnaround_o,
  output logic                overflowed_o,
  output logic                final_row_o
);

  pss_pkg::pss_cnt_t  cnt_q, cnt_d;
  logic               drop_q, drop_d;
  logic               valid_q;
  pss_pkg::pss_cnt_t  i_q, i_d, j_q, j_d;
  pss_pkg::pss_idx_t  sel_q, sel_d;
  pss_pkg::pss_word_t wi_q, wi_d, wm_q, wm_d;
  pss_pkg::pss_sum_t  run_q, run_d;
  pss_pkg::pss_tot_t  totw_q, totw_d, tott_q, tott_d;
  pss_pkg::pss_sum_t  avgw_q, avgw_d, avgt_q, avgt_d;

  pss_pkg::pss_id_t    job_id_q;
  pss_pkg::pss_burst_t job_burst_q;
  pss_pkg::pss_sum_t   wait_time_q, turnaround_q;
  logic                overflowed_q, final_row_q;

  logic               we;
  pss_pkg::pss_idx_t  waddr, raddr;
  pss_pkg::pss_word_t wdata, rdata;
  logic [$bits(pss_pkg::pss_word_t)-1:0] rdata_raw;
  pss_pkg::pss_tot_t  quotient;
  logic               div_done;
  logic               full;

  pss_ram #(
    .WIDTH ($bits(pss_pkg::pss_word_t)),
    .DEPTH (pss_pkg::MAX_PROCS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  assign rdata = pss_pkg::pss_word_t'(rdata_raw);

  pss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sel_t ? tott_q : totw_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign full  = (cnt_q == pss_pkg::pss_cnt_t'(pss_pkg::MAX_PROCS));
  assign raddr = cmd_i.rd_j ? j_q[pss_pkg::IDX_W-1:0] : i_q[pss_pkg::IDX_W-1:0];

  assign sts_o.last_i   = (pss_pkg::pss_cnt_t'(i_q + pss_pkg::pss_cnt_t'(1)) == cnt_q);
  assign sts_o.last_j   = (pss_pkg::pss_cnt_t'(j_q + pss_pkg::pss_cnt_t'(1)) == cnt_q);
  assign sts_o.div_done = div_done;

  // Store port: new jobs while loading, then the two halves of each sort swap.
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q[pss_pkg::IDX_W-1:0];
    wdata = '{id: pss_pkg::pss_id_t'(cnt_q) + pss_pkg::pss_id_t'(1),
              prio: prio_i, burst: burst_i};
    if (cmd_i.load) begin
      we = !full;
    end else if (cmd_i.wr_sel) begin
      we    = 1'b1;
      waddr = sel_q;
      wdata = wi_q;
    end else if (cmd_i.wr_i) begin
      we    = 1'b1;
      waddr = i_q[pss_pkg::IDX_W-1:0];
      wdata = wm_q;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    drop_d = drop_q;
    i_d    = i_q;
    j_d    = j_q;
    sel_d  = sel_q;
    wi_d   = wi_q;
    wm_d   = wm_q;
    run_d  = run_q;
    totw_d = totw_q;
    tott_d = tott_q;
    avgw_d = avgw_q;
    avgt_d = avgt_q;
    if (cmd_i.load) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        cnt_d = cnt_q + pss_pkg::pss_cnt_t'(1);
      end
      i_d    = '0;
      run_d  = '0;
      totw_d = '0;
      tott_d = '0;
    end
    if (cmd_i.clear) begin
      cnt_d  = '0;
      drop_d = 1'b0;
    end
    if (cmd_i.ld_i) begin
      wi_d  = rdata;
      wm_d  = rdata;
      sel_d = i_q[pss_pkg::IDX_W-1:0];
      j_d   = i_q + pss_pkg::pss_cnt_t'(1);
    end
    if (cmd_i.cmp_j) begin
      // Strict compare keeps the first index holding the smallest priority.
      if (rdata.prio < wm_q.prio) begin
        wm_d  = rdata;
        sel_d = j_q[pss_pkg::IDX_W-1:0];
      end
      j_d = j_q + pss_pkg::pss_cnt_t'(1);
    end
    if (cmd_i.wr_i) begin
      // Slot i is final here, so its wait and turnaround go into the totals.
      run_d  = run_q + pss_pkg::pss_sum_t'(wm_q.burst);
      totw_d = totw_q + pss_pkg::pss_tot_t'(run_q);
      tott_d = tott_q + pss_pkg::pss_tot_t'(run_d);
      i_d    = i_q + pss_pkg::pss_cnt_t'(1);
    end
    if (cmd_i.cap_w) begin
      avgw_d = quotient[pss_pkg::SUM_W-1:0];
    end
    if (cmd_i.cap_t) begin
      avgt_d = quotient[pss_pkg::SUM_W-1:0];
      i_d    = '0;
      run_d  = '0;
    end
    if (cmd_i.emit) begin
      run_d = run_q + pss_pkg::pss_sum_t'(rdata.burst);
      i_d   = i_q + pss_pkg::pss_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    sel_q  <= sel_d;
    wi_q   <= wi_d;
    wm_q   <= wm_d;
    run_q  <= run_d;
    totw_q <= totw_d;
    tott_q <= tott_d;
    avgw_q <= avgw_d;
    avgt_q <= avgt_d;
    if (cmd_i.emit) begin
      job_id_q     <= rdata.id;
      job_burst_q  <= rdata.burst;
      wait_time_q  <= run_q;
      turnaround_q <= run_q + pss_pkg::pss_sum_t'(rdata.burst);
      overflowed_q <= drop_q;
      final_row_q  <= sts_o.last_i;
    end
  end

  assign valid_o          = valid_q;
  assign job_id_o         = job_id_q;
  assign job_burst_o      = job_burst_q;
  assign wait_time_o      = wait_time_q;
  assign turnaround_o     = turnaround_q;
  assign avg_wait_o       = avgw_q;
  assign avg_turnaround_o = avgt_q;
  assign overflowed_o     = overflowed_q;
  assign final_row_o      = final_row_q;

endmodule

// ----- hw/rtl/pss_ctrl.sv -----
// Controller state machine: loading, selection sort, averaging and row emission.
// Depends on pss_pkg.
`timescale 1ns / 1ps

module pss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_i,
  input  pss_pkg::pss_sts_t sts_i,
  output pss_pkg::pss_cmd_t cmd_o,
  output logic              busy_o
);

  pss_pkg::pss_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pss_pkg::ST_IDLE: begin
        if (start_i && last_i) begin
          state_d = pss_pkg::ST_RD_I;
        end
      end
      pss_pkg::ST_RD_I:   state_d = pss_pkg::ST_LD_I;
      pss_pkg::ST_LD_I:   state_d = sts_i.last_i ? pss_pkg::ST_WR_SEL : pss_pkg::ST_RD_J;
      pss_pkg::ST_RD_J:   state_d = pss_pkg::ST_CMP_J;
      pss_pkg::ST_CMP_J:  state_d = sts_i.last_j ? pss_pkg::ST_WR_SEL : pss_pkg::ST_RD_J;
      pss_pkg::ST_WR_SEL: state_d = pss_pkg::ST_WR_I;
      pss_pkg::ST_WR_I:   state_d = sts_i.last_i ? pss_pkg::ST_DIV_W : pss_pkg::ST_RD_I;
      pss_pkg::ST_DIV_W:  state_d = pss_pkg::ST_WAIT_W;
      pss_pkg::ST_WAIT_W: begin
        if (sts_i.div_done) begin
          state_d = pss_pkg::ST_DIV_T;
        end
      end
      pss_pkg::ST_DIV_T:  state_d = pss_pkg::ST_WAIT_T;
      pss_pkg::ST_WAIT_T: begin
        if (sts_i.div_done) begin
          state_d = pss_pkg::ST_EM_RD;
        end
      end
      pss_pkg::ST_EM_RD:  state_d = pss_pkg::ST_EMIT;
      pss_pkg::ST_EMIT:   state_d = sts_i.last_i ? pss_pkg::ST_IDLE : pss_pkg::ST_EM_RD;
      default:            state_d = pss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      pss_pkg::ST_IDLE:   cmd_o.load = start_i;
      pss_pkg::ST_LD_I:   cmd_o.ld_i = 1'b1;
      pss_pkg::ST_RD_J:   cmd_o.rd_j = 1'b1;
      pss_pkg::ST_CMP_J:  cmd_o.cmp_j = 1'b1;
      pss_pkg::ST_WR_SEL: cmd_o.wr_sel = 1'b1;
      pss_pkg::ST_WR_I:   cmd_o.wr_i = 1'b1;
      pss_pkg::ST_DIV_W:  cmd_o.div_start = 1'b1;
      pss_pkg::ST_WAIT_W: cmd_o.cap_w = sts_i.div_done;
      pss_pkg::ST_DIV_T: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_t = 1'b1;
      end
      pss_pkg::ST_WAIT_T: begin
        cmd_o.div_sel_t = 1'b1;
        cmd_o.cap_t     = sts_i.div_done;
      end
      pss_pkg::ST_EMIT: begin
        cmd_o.emit  = 1'b1;
        cmd_o.clear = sts_i.last_i;
      end
      default:            cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != pss_pkg::ST_IDLE);

endmodule

// ----- hw/rtl/priority_schedule_stats_unit.sv -----
// Top level of the non-preemptive priority scheduler with batch statistics.
// Depends on pss_pkg, pss_ctrl and pss_dp (which holds pss_ram and pss_div).
//
// Usage:
// A job beat is taken at a rising edge with start high and busy low: burst_i,
// prio_i and last_i. Loading costs one cycle per job and raises no result.
// Up to 16 jobs are stored; later jobs of the same batch are dropped and the
// batch rows carry overflowed_o. A beat with last_i high closes the batch and
// busy goes high on the next cycle.
// For a batch of n stored jobs, the selection sort runs first (one store read
// port, scanned one entry at a time), then two 27-step serial divisions,
// then the rows are driven one by one, in schedule order. Busy drops in
// the cycle that carries the final row.
// Each row is on the result ports for one cycle with valid_o high; the
// receiver cannot stall it and must take it in that cycle.
// Reset clears the job count, the overflow flag and the controller; no
// stored job survives it, and no clearing pass is needed.
`timescale 1ns / 1ps

module priority_schedule_stats_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pss_pkg::pss_burst_t burst_i,
  input  pss_pkg::pss_prio_t  prio_i,
  input  logic                last_i,
  output logic                valid_o,
  output pss_pkg::pss_id_t    job_id_o,
  output pss_pkg::pss_burst_t job_burst_o,
  output pss_pkg::pss_sum_t   wait_time_o,
  output pss_pkg::pss_sum_t   turnaround_o,
  output pss_pkg::pss_sum_t   avg_wait_o,
  output pss_pkg::pss_sum_t   avg_turnaround_o,
  output logic                overflowed_o,
  output logic                final_row_o
);

  pss_pkg::pss_cmd_t cmd;
  pss_pkg::pss_sts_t sts;

  pss_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .last_i  (last_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  pss_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .burst_i          (burst_i),
    .prio_i           (prio_i),
    .valid_o          (valid_o),
    .job_id_o         (job_id_o),
    .job_burst_o      (job_burst_o),
    .wait_time_o      (wait_time_o),
    .turnaround_o     (turnaround_o),
    .avg_wait_o       (avg_wait_o),
    .avg_turnaround_o (avg_turnaround_o),
    .overflowed_o     (overflowed_o),
    .final_row_o      (final_row_o)
  );

endmodule

// ----- test/priority_schedule_stats_unit_checker.sv -----
// Scoreboard for the priority schedule statistics unit: tracks job beats and predicts the rows.
// Each emitted row is checked field by field against its prediction.
// Depends on pss_pkg for the field types and the batch capacity.
`timescale 1ns / 1ps

module priority_schedule_stats_unit_checker
  import pss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  pss_burst_t  burst_i,
  input  pss_prio_t   prio_i,
  input  logic        last_i,
  input  logic        valid_o,
  input  pss_id_t     job_id_o,
  input  pss_burst_t  job_burst_o,
  input  pss_sum_t    wait_time_o,
  input  pss_sum_t    turnaround_o,
  input  pss_sum_t    avg_wait_o,
  input  pss_sum_t    avg_turnaround_o,
  input  logic        overflowed_o,
  input  logic        final_row_o,
  output int unsigned fail_count,
  output int unsigned pending_rows,
  output int unsigned rows_checked,
  output int unsigned batch_count,
  output int unsigned overflow_batches
);

  typedef struct {
    pss_id_t    id;
    pss_burst_t burst;
    pss_sum_t   wait_t;
    pss_sum_t   tat;
    pss_sum_t   avg_w;
    pss_sum_t   avg_t;
    logic       ovf;
    logic       fin;
  } sched_row_t;

  sched_row_t  sched_rows_q[$];
  pss_burst_t  held_burst[MAX_PROCS];
  pss_prio_t   held_prio[MAX_PROCS];
  pss_id_t     held_id[MAX_PROCS];
  int unsigned held_count;
  logic        dropped;

  initial begin
    fail_count       = 0;
    pending_rows     = 0;
    rows_checked     = 0;
    batch_count      = 0;
    overflow_batches = 0;
    held_count       = 0;
    dropped          = 1'b0;
  end

  // Stores the job, and on the closing beat orders the batch and queues its rows.
  function automatic void schedule_job(pss_burst_t b, pss_prio_t p, logic closes);
    pss_burst_t  sb[MAX_PROCS];
    pss_prio_t   sp[MAX_PROCS];
    pss_id_t     sid[MAX_PROCS];
    pss_burst_t  tb;
    pss_prio_t   tp;
    pss_id_t     ti;
    int unsigned sel;
    logic [31:0] run_sum;
    logic [31:0] tot_wait;
    logic [31:0] tot_tat;
    sched_row_t  r;

    if (held_count < MAX_PROCS) begin
      held_burst[held_count] = b;
      held_prio[held_count]  = p;
      held_id[held_count]    = pss_id_t'(held_count + 1);
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!closes) return;

    if (held_count != 0) begin
      for (int i = 0; i < held_count; i++) begin
        sb[i]  = held_burst[i];
        sp[i]  = held_prio[i];
        sid[i] = held_id[i];
      end
      // Plain selection sort: the first minimum wins, so equal priorities can reorder.
      for (int i = 0; i < held_count; i++) begin
        sel = i;
        for (int j = i + 1; j < held_count; j++)
          if (sp[j] < sp[sel]) sel = j;
        tp = sp[i];  sp[i]  = sp[sel];  sp[sel]  = tp;
        tb = sb[i];  sb[i]  = sb[sel];  sb[sel]  = tb;
        ti = sid[i]; sid[i] = sid[sel]; sid[sel] = ti;
      end
      run_sum  = 0;
      tot_wait = 0;
      tot_tat  = 0;
      for (int i = 0; i < held_count; i++) begin
        tot_wait += run_sum;
        run_sum  += 32'(sb[i]);
        tot_tat  += run_sum;
      end
      run_sum = 0;
      for (int i = 0; i < held_count; i++) begin
        r.id     = sid[i];
        r.burst  = sb[i];
        r.wait_t = pss_sum_t'(run_sum);
        r.tat    = pss_sum_t'(run_sum + 32'(sb[i]));
        r.avg_w  = pss_sum_t'(tot_wait / held_count);
        r.avg_t  = pss_sum_t'(tot_tat / held_count);
        r.ovf    = dropped;
        r.fin    = (i + 1 == held_count);
        sched_rows_q.push_back(r);
        run_sum += 32'(sb[i]);
      end
      batch_count++;
      if (dropped) overflow_batches++;
    end
    held_count = 0;
    dropped    = 1'b0;
  endfunction

  function automatic void check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    sched_row_t r;
    if (rst_ni) begin
      if ($isunknown(valid_o)) begin
        fail_count++;
        $display("%0t: valid_o is unknown after reset", $time);
      end else if (valid_o) begin
        if (sched_rows_q.size() == 0) begin
          fail_count++;
          $display("%0t: row for job %0d arrived with no row expected", $time, job_id_o);
        end else begin
          r = sched_rows_q.pop_front();
          check_field("job_id", 32'(r.id), 32'(job_id_o));
          check_field("job_burst", 32'(r.burst), 32'(job_burst_o));
          check_field("wait_time", 32'(r.wait_t), 32'(wait_time_o));
          check_field("turnaround", 32'(r.tat), 32'(turnaround_o));
          check_field("avg_wait", 32'(r.avg_w), 32'(avg_wait_o));
          check_field("avg_turnaround", 32'(r.avg_t), 32'(avg_turnaround_o));
          check_field("overflowed", 32'(r.ovf), 32'(overflowed_o));
          check_field("final_row", 32'(r.fin), 32'(final_row_o));
          rows_checked++;
        end
      end
      // A closing beat cannot produce a row in the cycle it is taken, so order here is safe.
      if (start && !busy) schedule_job(burst_i, prio_i, last_i);
      pending_rows = sched_rows_q.size();
    end
  end

endmodule

// ----- test/priority_schedule_stats_unit_tb.sv -----
// Top of the testbench for priority_schedule_stats_unit: clock, reset, job beats and verdict.
// Depends on pss_pkg, the unit itself and priority_schedule_stats_unit_checker.
`timescale 1ns / 1ps

module priority_schedule_stats_unit_tb;
  import pss_pkg::*;

  localparam int unsigned JOB_TARGET     = 470;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  pss_burst_t burst_i;
  pss_prio_t  prio_i;
  logic       last_i;
  logic       valid_o;
  pss_id_t    job_id_o;
  pss_burst_t job_burst_o;
  pss_sum_t   wait_time_o;
  pss_sum_t   turnaround_o;
  pss_sum_t   avg_wait_o;
  pss_sum_t   avg_turnaround_o;
  logic       overflowed_o;
  logic       final_row_o;

  int unsigned fail_count;
  int unsigned pending_rows;
  int unsigned rows_checked;
  int unsigned batch_count;
  int unsigned overflow_batches;
  int unsigned jobs_sent = 0;
  int unsigned idle_cycles = 0;
  logic        gaps_on = 1'b1;

  always #5 clk_i = ~clk_i;

  priority_schedule_stats_unit dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .burst_i,
    .prio_i,
    .last_i,
    .valid_o,
    .job_id_o,
    .job_burst_o,
    .wait_time_o,
    .turnaround_o,
    .avg_wait_o,
    .avg_turnaround_o,
    .overflowed_o,
    .final_row_o
  );

  priority_schedule_stats_unit_checker u_checker (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .burst_i,
    .prio_i,
    .last_i,
    .valid_o,
    .job_id_o,
    .job_burst_o,
    .wait_time_o,
    .turnaround_o,
    .avg_wait_o,
    .avg_turnaround_o,
    .overflowed_o,
    .final_row_o,
    .fail_count,
    .pending_rows,
    .rows_checked,
    .batch_count,
    .overflow_batches
  );

  // Drives one job beat, holds it until taken, then maybe leaves a gap.
  task automatic send_job(input pss_burst_t b, input pss_prio_t p, input logic closes);
    start   <= 1'b1;
    burst_i <= b;
    prio_i  <= p;
    last_i  <= closes;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    jobs_sent++;
    if (gaps_on && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Holds off new beats until every predicted row has been seen.
  task automatic drain_rows();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_rows != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat taken and no row seen for %0d cycles", $time, idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_jobs;
    int unsigned pick;
    int unsigned batch_no;
    logic        ties;
    pss_burst_t  b;
    pss_prio_t   p;

    rst_ni  <= 1'b0;
    start   <= 1'b0;
    burst_i <= '0;
    prio_i  <= '0;
    last_i  <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-job batches at both extremes of burst and priority.
    send_job(16'd0, 8'd0, 1'b1);
    send_job(16'hFFFF, 8'hFF, 1'b1);
    // Equal priorities ahead of a smaller one: the sort swaps them out of arrival order.
    send_job(16'd300, 8'd1, 1'b0);
    send_job(16'd1, 8'd1, 1'b0);
    send_job(16'd2, 8'd0, 1'b1);
    // Full batch with maximal bursts and many ties, two dropped beats, the last one closing.
    for (int k = 0; k < MAX_PROCS + 2; k++)
      send_job((k % 2 == 0) ? 16'hFFFF : pss_burst_t'(k * 4099),
               pss_prio_t'((k * 7) % 5), k == MAX_PROCS + 1);
    drain_rows();

    batch_no = 0;
    while (jobs_sent < JOB_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 70)      n_jobs = $urandom_range(1, 6);
      else if (pick < 90) n_jobs = $urandom_range(7, MAX_PROCS);
      else                n_jobs = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
      ties = ($urandom_range(1) == 1);
      for (int k = 0; k < n_jobs; k++) begin
        gaps_on = !(jobs_sent >= 250 && jobs_sent < 350);
        case ($urandom_range(9))
          0:       b = '0;
          1:       b = '1;
          default: b = pss_burst_t'($urandom);
        endcase
        if (ties)                        p = pss_prio_t'($urandom_range(3));
        else if ($urandom_range(9) == 0) p = $urandom_range(1) ? '1 : '0;
        else                             p = pss_prio_t'($urandom);
        send_job(b, p, k == n_jobs - 1);
      end
      batch_no++;
      if (batch_no % 12 == 5) drain_rows();
    end

    drain_rows();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    $display("Run covered %0d jobs in %0d batches (%0d overflowing) and checked %0d rows.",
             jobs_sent, batch_count, overflow_batches, rows_checked);
    if (fail_count == 0 && pending_rows == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
